FILE: hw/rtl/wrv_pkg.sv
package wrv_pkg;

    localparam int COUNT_BITS = 16;
    localparam int SAMPLE_W   = 16;
    localparam int M2_W       = 46;
    localparam int TDATA_W    = 80;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [M2_W-1:0]       M2_MAX    = '1;

    localparam int DIV_STEPS = SAMPLE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic load;
        logic div_step;
        logic mean_upd;
        logic mul;
        logic acc;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic count_full;
    } status_t;

endpackage

FILE: hw/rtl/wrv_datapath.sv
module wrv_datapath
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  wrv_pkg::cmd_t                cmd,
    output wrv_pkg::status_t             status,
    input  logic [wrv_pkg::SAMPLE_W-1:0] sample,
    output logic [wrv_pkg::TDATA_W-1:0]  out_tdata,
    output logic                         out_tuser
);

    localparam int CB = wrv_pkg::COUNT_BITS;
    localparam int SW = wrv_pkg::SAMPLE_W;
    localparam int MW = wrv_pkg::M2_W;

    logic [CB-1:0]   count_reg;
    logic [SW-1:0]   mean_reg;
    logic [MW-1:0]   m2_reg;

    logic [SW-1:0]   x_reg;
    logic            neg_reg;
    logic [SW-1:0]   mag_reg;
    logic [SW-1:0]   quo_reg;
    logic [CB-1:0]   rem_reg;
    logic [SW-1:0]   dev2_reg;
    logic [2*SW-1:0] prod_reg;
    logic            sat_reg;

    logic [wrv_pkg::TDATA_W-1:0] out_tdata_reg;
    logic                        out_tuser_reg;

    logic [SW:0]   diff;
    logic [SW:0]   diff2;
    logic [CB:0]   r_shift;
    logic          r_ge;
    logic [CB:0]   r_sub;
    logic [SW-1:0] new_mean;
    logic [MW:0]   m2_sum;

    assign status.count_full = (count_reg == wrv_pkg::COUNT_MAX);

    assign diff    = {1'b0, sample} - {1'b0, mean_reg};
    assign r_shift = {rem_reg, quo_reg[SW-1]};
    assign r_ge    = (r_shift >= {1'b0, count_reg});
    assign r_sub   = r_shift - {1'b0, count_reg};
    // quotient magnitude truncates toward zero, so apply the sign afterward
    assign new_mean = neg_reg ? (mean_reg - quo_reg) : (mean_reg + quo_reg);
    assign diff2   = {1'b0, x_reg} - {1'b0, new_mean};
    assign m2_sum  = {1'b0, m2_reg} + (MW+1)'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            mean_reg  <= '0;
            m2_reg    <= '0;
        end
        else
        begin
            if (cmd.load && !status.count_full)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.mean_upd)
            begin
                mean_reg <= new_mean;
            end
            if (cmd.acc)
            begin
                m2_reg <= m2_sum[MW] ? wrv_pkg::M2_MAX : m2_sum[MW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg   <= sample;
            neg_reg <= diff[SW];
            mag_reg <= diff[SW] ? SW'(-diff) : diff[SW-1:0];
            quo_reg <= diff[SW] ? SW'(-diff) : diff[SW-1:0];
            rem_reg <= '0;
            sat_reg <= status.count_full;
        end
        if (cmd.div_step)
        begin
            rem_reg <= r_ge ? r_sub[CB-1:0] : r_shift[CB-1:0];
            quo_reg <= {quo_reg[SW-2:0], r_ge};
        end
        if (cmd.mean_upd)
        begin
            dev2_reg <= diff2[SW] ? SW'(-diff2) : diff2[SW-1:0];
        end
        if (cmd.mul)
        begin
            prod_reg <= mag_reg * dev2_reg;
        end
        if (cmd.out_load)
        begin
            out_tdata_reg <= {2'b00, m2_reg, mean_reg, 16'(count_reg)};
            out_tuser_reg <= sat_reg;
        end
    end

    assign out_tdata = out_tdata_reg;
    assign out_tuser = out_tuser_reg;

endmodule

FILE: hw/rtl/wrv_ctrl.sv
module wrv_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  wrv_pkg::status_t status,
    output wrv_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_MEAN = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_ACC  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    localparam int CW = wrv_pkg::DIV_CNT_W;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] bit_cnt_reg, bit_cnt_next;
    logic          out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        bit_cnt_next   = bit_cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    bit_cnt_next = '0;
                    // full count: skip the update and report the held state
                    state_next   = status.count_full ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == CW'(wrv_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                cmd.mean_upd = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hw/rtl/welford_running_variance.sv
// Welford running mean and variance: each accepted sample (unsigned Q1.15) updates the
// count, the mean and the accumulated squared deviation M2 (Q.30, saturating at 2^46-1)
// and produces one result with the state after the update. The sample is loaded at the
// accepting edge; the result is then formed by a restoring division of the deviation
// by the new count, one quotient bit per cycle, then mean update, multiply, accumulate
// and output load, which waits while an earlier result still holds the output register.
// A saturated request (count already full) goes straight to the output load and leaves
// the state unchanged. The input is taken again the cycle after the result is loaded,
// while that result may still wait in the output register, so a new sample is taken
// only once the last one's result has been loaded. State clears on reset.
module welford_running_variance
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [wrv_pkg::SAMPLE_W-1:0] s_axis_tdata,  // [15:0] sample
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [15:0] sample_count, [31:16] running_mean, [77:32] sum_sq_dev, [79:78] zero
    output logic [wrv_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic                         m_axis_tuser   // [0] saturated
);

    wrv_pkg::cmd_t    cmd;
    wrv_pkg::status_t status;

    wrv_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    wrv_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .sample    (s_axis_tdata),
        .out_tdata (m_axis_tdata),
        .out_tuser (m_axis_tuser)
    );

endmodule

FILE: hw/rtl/wrv_checker.sv
module wrv_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic [wrv_pkg::SAMPLE_W-1:0] s_axis_tdata,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [wrv_pkg::TDATA_W-1:0]  m_axis_tdata,
    input logic                         m_axis_tuser
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

    // one request at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a request is in progress");

    // saturated results report a full count
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[15:0] == 16'(wrv_pkg::COUNT_MAX))
    else $error("saturated flag without full count");

    // padding bits stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[79:78] == 2'b00)
    else $error("padding bits set");

endmodule

bind welford_running_variance wrv_checker u_wrv_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: sim/wrv_stats_checker.sv
`timescale 1ns / 100ps

module wrv_stats_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic [wrv_pkg::SAMPLE_W-1:0] s_axis_tdata,   // [15:0] sample
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [15:0] sample_count, [31:16] running_mean, [77:32] sum_sq_dev, [79:78] zero
    input  logic [wrv_pkg::TDATA_W-1:0]  m_axis_tdata,
    input  logic                         m_axis_tuser,   // [0] saturated
    output int                           mismatch_count,
    output int                           pending_results
);

    localparam int SW = wrv_pkg::SAMPLE_W;
    localparam int MW = wrv_pkg::M2_W;

    typedef struct packed {
        logic [15:0]   count;
        logic [SW-1:0] mean;
        logic [MW-1:0] m2;
        logic          sat;
    } stats_t;

    logic [wrv_pkg::COUNT_BITS-1:0] acc_count;
    logic [SW-1:0]                  acc_mean;
    logic [MW-1:0]                  acc_m2;
    stats_t                         pending_stats [$];
    int                             bad;

    initial
    begin
        mismatch_count  = 0;
        pending_results = 0;
        bad             = 0;
        acc_count       = '0;
        acc_mean        = '0;
        acc_m2          = '0;
    end

    // Advance the running statistics by one sample and return what the block must report.
    function automatic stats_t welford_update(input logic [SW-1:0] smp);
        longint          x;
        longint          m;
        longint          n;
        longint          delta;
        longint          mean_next;
        longint          dev;
        longint          mag_d;
        longint          mag_e;
        longint unsigned inc;
        longint unsigned room;
        stats_t          r;
        r.sat = 1'b1;
        if (acc_count != wrv_pkg::COUNT_MAX)
        begin
            r.sat     = 1'b0;
            acc_count = acc_count + 1'b1;
            x         = longint'(smp);
            m         = longint'(acc_mean);
            n         = longint'(acc_count);
            delta     = x - m;
            // signed division truncates toward zero
            mean_next = m + delta / n;
            dev       = x - mean_next;
            mag_d     = (delta < 0) ? -delta : delta;
            mag_e     = (dev < 0) ? -dev : dev;
            inc       = mag_d * mag_e;
            acc_mean  = mean_next[SW-1:0];
            room      = 64'(wrv_pkg::M2_MAX) - 64'(acc_m2);
            // clamp at the top instead of wrapping
            if (inc > room)
                acc_m2 = wrv_pkg::M2_MAX;
            else
                acc_m2 = MW'(64'(acc_m2) + inc);
        end
        r.count = acc_count[15:0];
        r.mean  = acc_mean;
        r.m2    = acc_m2;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        stats_t want;
        if (!rst_n)
        begin
            acc_count = '0;
            acc_mean  = '0;
            acc_m2    = '0;
            pending_stats.delete();
        end
        else
        begin
            // check the outgoing result first: a request taken this edge cannot be answered yet
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_stats.size() == 0)
                begin
                    bad++;
                    if (bad <= 10)
                        $display("unexpected result: tdata=%h tuser=%b",
                                 m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want = pending_stats.pop_front();
                    if (m_axis_tdata[15:0] !== want.count
                        || m_axis_tdata[16 +: SW] !== want.mean
                        || m_axis_tdata[32 +: MW] !== want.m2
                        || m_axis_tuser !== want.sat)
                    begin
                        bad++;
                        if (bad <= 10)
                            $display({"mismatch: count exp %0d got %0d, mean exp %0d got %0d, ",
                                      "m2 exp %0d got %0d, sat exp %0b got %0b"},
                                     want.count, m_axis_tdata[15:0],
                                     want.mean, m_axis_tdata[16 +: SW],
                                     want.m2, m_axis_tdata[32 +: MW],
                                     want.sat, m_axis_tuser);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_stats.push_back(welford_update(s_axis_tdata));
        end
        mismatch_count  <= bad;
        pending_results <= pending_stats.size();
    end

endmodule

FILE: sim/tb_welford_running_variance.sv
`timescale 1ns / 100ps

module tb_welford_running_variance;

    localparam int SW           = wrv_pkg::SAMPLE_W;
    localparam int RANDOM_ITEMS = 1250;
    localparam int FINAL_ITEMS  = 32;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 400;

    logic                               clk           = 1'b0;
    logic                               rst_n         = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [SW-1:0]                      s_axis_tdata  = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [wrv_pkg::TDATA_W-1:0]        m_axis_tdata;
    logic                               m_axis_tuser;

    int   mismatch_count;
    int   pending_results;
    int   cycle_cnt    = 0;
    logic idle_on      = 1'b1;

    welford_running_variance u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    wrv_stats_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Offer one sample, hold it until taken, then maybe leave a gap.
    task automatic offer_sample(input logic [SW-1:0] value);
        s_axis_tdata  <= value;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // Result side: random stalls, plus one long hold-off so the block backs up.
    initial
    begin : result_sink
        int  taken;
        bit  held;
        taken = 0;
        held  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                taken++;
            if (!held && taken >= 30)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        logic [SW-1:0] v;
        v = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, rising and falling mean, patterns above 1.0
        offer_sample(16'h0000);
        offer_sample(16'h0000);
        offer_sample(16'h8000);
        offer_sample(16'h8000);
        offer_sample(16'h0000);
        offer_sample(16'hFFFF);
        offer_sample(16'h0001);
        offer_sample(16'h7FFF);
        offer_sample(16'h4000);
        offer_sample(16'h5555);
        offer_sample(16'hAAAA);
        offer_sample(16'hFFFF);
        offer_sample(16'hFFFF);
        offer_sample(16'h0000);
        offer_sample(16'h0001);
        offer_sample(16'h3039);
        offer_sample(16'h8000);
        offer_sample(16'hFFFE);

        repeat (RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       v = SW'($urandom_range(0, 65535));
                1:
                begin
                    case ($urandom_range(0, 4))
                        0:       v = 16'h0000;
                        1:       v = 16'h0001;
                        2:       v = 16'h7FFF;
                        3:       v = 16'h8000;
                        default: v = 16'hFFFF;
                    endcase
                end
                2:       v = v;
                default: v = SW'($urandom_range(0, 32768));
            endcase
            offer_sample(v);
        end

        // last stretch at full rate on both sides
        idle_on <= 1'b0;
        repeat (FINAL_ITEMS)
            offer_sample(SW'($urandom_range(0, 65535)));
        s_axis_tvalid <= 1'b0;

        while (pending_results != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
